// File: rtl/dg3_pkg.sv
// ----------------------------------------------------------------------------
// dg3_pkg
// Shared constants, types and helpers of the 3x3 directional gradient block.
// ----------------------------------------------------------------------------
package dg3_pkg;

    // image limits and field widths
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 12;
    localparam int SHIFT_W    = 4;
    localparam int PIX_W      = 8;
    localparam int MAG_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // widths used for comparing configured sizes against the limits
    localparam int WCMP_W = (DIM_W > COL_W + 1) ? DIM_W : COL_W + 1;
    localparam int HCMP_W = (DIM_W > ROW_W + 1) ? DIM_W : ROW_W + 1;

    // magnitude ceiling
    localparam logic [MAG_W-1:0] MAG_CLAMP = MAG_W'(253);

    // result buffer sizing
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    // reset values of the configuration registers
    localparam logic [DIM_W-1:0]   WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0]   HEIGHT_RST = DIM_W'(480);
    localparam logic [SHIFT_W-1:0] SHIFT_RST  = '0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = CFG_IDX_W'(2);

    // direction codes
    typedef enum logic [1:0] {
        DIR_VERT = 2'd0,
        DIR_ANTI = 2'd1,
        DIR_HORZ = 2'd2,
        DIR_DIAG = 2'd3
    } dir_t;

    // 3x3 window: [row top..bottom][column left..right]
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    // control that travels alongside the window
    typedef struct packed {
        logic emit;
        logic last;
    } ctl_t;

    // one result
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        dir_t             dir;
        logic             last;
    } res_t;

    // effective row length: below 3 acts as 3, above the limit as the limit
    function automatic logic [COL_W:0] clamp_width(input logic [DIM_W-1:0] v);
        logic [WCMP_W-1:0] ve;
        ve = WCMP_W'(v);
        if (ve < WCMP_W'(3))
            return (COL_W+1)'(3);
        else if (ve > WCMP_W'(MAX_WIDTH))
            return (COL_W+1)'(MAX_WIDTH);
        else
            return (COL_W+1)'(ve);
    endfunction

    // effective frame height, same rule
    function automatic logic [ROW_W:0] clamp_height(input logic [DIM_W-1:0] v);
        logic [HCMP_W-1:0] ve;
        ve = HCMP_W'(v);
        if (ve < HCMP_W'(3))
            return (ROW_W+1)'(3);
        else if (ve > HCMP_W'(MAX_HEIGHT))
            return (ROW_W+1)'(MAX_HEIGHT);
        else
            return (ROW_W+1)'(ve);
    endfunction

endpackage

// File: rtl/dg3_pix_if.sv
// ----------------------------------------------------------------------------
// dg3_pix_if
// Pixel request channel: valid/ready with one raster-order pixel.
// ----------------------------------------------------------------------------
interface dg3_pix_if import dg3_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);

endinterface

// File: rtl/dg3_res_if.sv
// ----------------------------------------------------------------------------
// dg3_res_if
// Result request channel: valid/ready with one gradient result.
// ----------------------------------------------------------------------------
interface dg3_res_if import dg3_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic [1:0]       direction;
    logic             last_in_frame;

    modport source (output valid, output magnitude, output direction,
                    output last_in_frame, input ready);
    modport sink   (input valid, input magnitude, input direction,
                    input last_in_frame, output ready);

endinterface

// File: rtl/dg3_cfg_if.sv
// ----------------------------------------------------------------------------
// dg3_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface dg3_cfg_if import dg3_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// File: rtl/dg3_ram.sv
// ----------------------------------------------------------------------------
// dg3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dg3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/dg3_line_buf.sv
// ----------------------------------------------------------------------------
// dg3_line_buf
// Raster position counters, the two line stores with read-modify-write and
// forwarding, and the 3x3 window register.
// ----------------------------------------------------------------------------
module dg3_line_buf import dg3_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             acc,
    input  logic [PIX_W-1:0] pixel,
    input  logic             frame_start,
    input  logic [COL_W:0]   w_eff,
    input  logic [ROW_W:0]   h_eff,
    output logic             s1_emit,
    output ctl_t             win_ctl,
    output win_t             win
);

    // position of the next pixel
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // read stage
    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             s1_fwd_reg;
    logic [PIX_W-1:0] fwd_top_reg;
    logic [PIX_W-1:0] fwd_mid_reg;

    // window stage
    win_t win_reg;
    ctl_t ctl_reg;

    logic [COL_W-1:0] col_start, col_c;
    logic [ROW_W-1:0] row_start, row_c;
    logic [COL_W:0]   w_last;
    logic [ROW_W:0]   h_last;
    logic             col_wrap, row_wrap;
    logic             acc_emit, acc_last;
    logic [PIX_W-1:0] top_rd, mid_rd, top_eff, mid_eff;

    // position of the incoming pixel, clamped to the frame
    always_comb
    begin
        w_last    = w_eff - 1'b1;
        h_last    = h_eff - 1'b1;
        col_start = frame_start ? '0 : col_reg;
        row_start = frame_start ? '0 : row_reg;
        col_c     = ({1'b0, col_start} >= w_eff) ? w_last[COL_W-1:0] : col_start;
        row_c     = ({1'b0, row_start} >= h_eff) ? h_last[ROW_W-1:0] : row_start;
        col_wrap  = ({1'b0, col_c} == w_last);
        row_wrap  = ({1'b0, row_c} == h_last);
        acc_emit  = (row_c >= ROW_W'(2)) && (col_c >= COL_W'(2));
        acc_last  = col_wrap && row_wrap;
        col_next  = col_wrap ? '0 : col_c + 1'b1;
        if (col_wrap)
            row_next = row_wrap ? '0 : row_c + 1'b1;
        else
            row_next = row_c;
    end

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores, read at accept, written back in the following cycle
    dg3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (mid_eff),
        .raddr (col_c),
        .rdata (top_rd)
    );

    dg3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .raddr (col_c),
        .rdata (mid_rd)
    );

    // forwarded data wins when the previous pixel wrote the same column
    assign top_eff = s1_fwd_reg ? fwd_top_reg : top_rd;
    assign mid_eff = s1_fwd_reg ? fwd_mid_reg : mid_rd;

    // read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= acc;
            s1_emit_reg  <= acc && acc_emit;
        end
    end

    // read stage payload and forwarding capture
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_last_reg <= acc_last;
            s1_col_reg  <= col_c;
            s1_pix_reg  <= pixel;
            s1_fwd_reg  <= s1_valid_reg && (s1_col_reg == col_c);
            fwd_top_reg <= mid_eff;
            fwd_mid_reg <= s1_pix_reg;
        end
    end

    // window shift, newest column on the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top_eff;
            win_reg[1][2] <= mid_eff;
            win_reg[2][2] <= s1_pix_reg;
        end
    end

    // window stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg.emit <= s1_emit_reg;
            ctl_reg.last <= s1_last_reg;
        end
    end

    assign s1_emit = s1_emit_reg;
    assign win_ctl = ctl_reg;
    assign win     = win_reg;

endmodule

// File: rtl/dg3_grad.sv
// ----------------------------------------------------------------------------
// dg3_grad
// Four absolute differences across the window centre, thresholded and
// clamped mean magnitude, and the direction of the largest difference.
// ----------------------------------------------------------------------------
module dg3_grad import dg3_pkg::*; (
    input  win_t               win,
    input  ctl_t               ctl,
    input  logic [SHIFT_W-1:0] shift,
    output logic               push,
    output res_t               res
);

    logic [PIX_W-1:0] gh, gd, gv, ga, best;
    logic [PIX_W+1:0] sum;
    logic [MAG_W-1:0] mean;
    dir_t             code;

    function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // differences and direction, earlier one wins a tie
    always_comb
    begin
        gh   = absdiff(win[1][0], win[1][2]);
        gd   = absdiff(win[0][0], win[2][2]);
        gv   = absdiff(win[0][1], win[2][1]);
        ga   = absdiff(win[0][2], win[2][0]);
        best = gh;
        code = DIR_HORZ;
        if (best < gd)
        begin
            best = gd;
            code = DIR_DIAG;
        end
        if (best < gv)
        begin
            best = gv;
            code = DIR_VERT;
        end
        if (best < ga)
        begin
            best = ga;
            code = DIR_ANTI;
        end
    end

    // mean, threshold and clamp
    always_comb
    begin
        sum  = (PIX_W+2)'(gh) + (PIX_W+2)'(gd) + (PIX_W+2)'(gv) + (PIX_W+2)'(ga);
        mean = sum[PIX_W+1:2];
        if ((mean >> shift) == '0)
            res.mag = '0;
        else if (mean > MAG_CLAMP)
            res.mag = MAG_CLAMP;
        else
            res.mag = mean;
        res.dir  = code;
        res.last = ctl.last;
    end

    assign push = ctl.emit;

endmodule

// File: rtl/dg3_out_fifo.sv
// ----------------------------------------------------------------------------
// dg3_out_fifo
// Small result queue that decouples the pipeline from a stalling receiver.
// ----------------------------------------------------------------------------
module dg3_out_fifo import dg3_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  res_t       push_data,
    output logic [CNT_W-1:0] count,
    dg3_res_if.source  res_out
);

    res_t             buf_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    res_t             head;

    assign pop = res_out.valid && res_out.ready;

    // occupancy
    always_comb
    begin
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    // head of queue drives the channel
    assign head                  = buf_reg[rd_ptr_reg];
    assign res_out.valid         = (count_reg != '0);
    assign res_out.magnitude     = head.mag;
    assign res_out.direction     = head.dir;
    assign res_out.last_in_frame = head.last;
    assign count                 = count_reg;

endmodule

// File: rtl/directional_gradient_3x3.sv
// ----------------------------------------------------------------------------
// directional_gradient_3x3
// Streaming 3x3 directional gradient magnitude and direction.
//
// Pixels enter on pix_in in raster order, one request per cycle at most;
// frame_start places a pixel at the top-left corner. Each interior pixel
// yields one request on res_out: mean of the horizontal, diagonal, vertical
// and anti-diagonal differences (zeroed below 2^threshold_shift, clamped to
// 253), the code of the largest difference, and a flag on the frame's last
// interior pixel. Border pixels give nothing.
// Throughput is one pixel per cycle while pix_in.ready is high, set by the
// single read and write port of each line store; a result passes the read
// stage and the window register. The user must write registers on cfg (0
// width, 1 height, 2 shift) only while idle; the block does not enforce it.
// Reset clears the position counters, the window and the result queue and
// loads width 640, height 480, shift 0; no clearing pass is needed.
// A four-entry result queue absorbs receiver stalls; pix_in.ready drops only
// when the queue plus results in flight would overflow it.
// ----------------------------------------------------------------------------
module directional_gradient_3x3 import dg3_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    dg3_pix_if.sink   pix_in,
    dg3_cfg_if.sink   cfg,
    dg3_res_if.source res_out
);

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [SHIFT_W-1:0] shift_reg;

    logic [COL_W:0]   w_eff;
    logic [ROW_W:0]   h_eff;
    logic             acc;
    logic             s1_emit;
    ctl_t             win_ctl;
    win_t             win;
    logic             push;
    res_t             res;
    logic [CNT_W-1:0] fifo_count;
    logic [CNT_W-1:0] occ;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            shift_reg  <= SHIFT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_WIDTH:  width_reg  <= cfg.data[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg.data[DIM_W-1:0];
                CFG_SHIFT:  shift_reg  <= cfg.data[SHIFT_W-1:0];
                default:    ;
            endcase
        end
    end

    assign w_eff = clamp_width(width_reg);
    assign h_eff = clamp_height(height_reg);

    // accept while the queue can hold every result in flight
    assign occ          = fifo_count + CNT_W'(s1_emit) + CNT_W'(win_ctl.emit);
    assign pix_in.ready = (occ < CNT_W'(FIFO_DEPTH));
    assign acc          = pix_in.valid && pix_in.ready;

    // line stores and window
    dg3_line_buf u_line_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .pixel       (pix_in.pixel),
        .frame_start (pix_in.frame_start),
        .w_eff       (w_eff),
        .h_eff       (h_eff),
        .s1_emit     (s1_emit),
        .win_ctl     (win_ctl),
        .win         (win)
    );

    // gradient arithmetic
    dg3_grad u_grad (
        .win   (win),
        .ctl   (win_ctl),
        .shift (shift_reg),
        .push  (push),
        .res   (res)
    );

    // result queue
    dg3_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .count     (fifo_count),
        .res_out   (res_out)
    );

endmodule
